@@ hdl/work_stealing_chunk_allocator_macros.svh @@
// Assertion helpers for the checker file.
`ifndef WORK_STEALING_CHUNK_ALLOCATOR_MACROS_SVH
`define WORK_STEALING_CHUNK_ALLOCATOR_MACROS_SVH

// Clocked check, off while reset is held.
`define WSCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define WSCA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/wsca_pkg.sv @@
package wsca_pkg;

  localparam int MaxWorkers         = 16;
  localparam int MaxChunksPerWorker = 64;

  localparam int WorkerCountW     = 5;
  localparam int ChunksPerWorkerW = 7;
  localparam int CfgDataW         = 7;
  localparam int CfgIdxW          = 1;
  localparam int WorkerIdW        = 4;
  localparam int ChunkIndexW      = 10;
  localparam int TotalChunksW     = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORKER_COUNT      = 1'b0,
    CFG_CHUNKS_PER_WORKER = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_REQUEST = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } wsca_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic out_free;
  } wsca_sts_t;

endpackage

@@ hdl/wsca_ram.sv @@
module wsca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/wsca_ctrl.sv @@
module wsca_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wsca_pkg::wsca_sts_t sts_i,
  output wsca_pkg::wsca_cmd_t cmd_o
);

  import wsca_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // only a grant needs the queue table read
          state_d = sts_i.hit ? ST_READ : ST_UPD;
        end
      end
      ST_READ: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/wsca_dp.sv @@
module wsca_dp #(
  parameter int MAX_WORKERS           = wsca_pkg::MaxWorkers,
  parameter int MAX_CHUNKS_PER_WORKER = wsca_pkg::MaxChunksPerWorker
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wsca_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [wsca_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                func_i,
  input  logic [wsca_pkg::WorkerIdW-1:0]      worker_id_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                granted_o,
  output logic [wsca_pkg::ChunkIndexW-1:0]    chunk_index_o,
  output logic [wsca_pkg::TotalChunksW-1:0]   pool_size_o,
  output logic                                bad_worker_o,
  input  wsca_pkg::wsca_cmd_t                 cmd_i,
  output wsca_pkg::wsca_sts_t                 sts_o
);

  import wsca_pkg::*;

  localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int WCW = $clog2(MAX_WORKERS + 1);
  localparam int PW  = $clog2(MAX_CHUNKS_PER_WORKER + 1);
  localparam int CW  = $clog2(MAX_WORKERS * MAX_CHUNKS_PER_WORKER + 1);
  localparam int TW  = WCW + PW;
  localparam int XW  = WW + PW + 1;

  // configuration
  logic [WCW-1:0] wc_q, wc_d;
  logic [PW-1:0]  cpw_q, cpw_d;
  logic [WorkerCountW-1:0]     wc_raw;
  logic [ChunksPerWorkerW-1:0] cpw_raw;
  logic           refill;

  // queue state
  logic [MAX_WORKERS-1:0] vld_q, vld_d;
  logic [MAX_WORKERS-1:0] avail_q, avail_d;
  logic [CW-1:0]          cnt_q, cnt_d;

  // per-item decision
  logic          hit_q, own_q, bad_q;
  logic [WW-1:0] tgt_q;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic                    granted_q;
  logic [ChunkIndexW-1:0]  idx_q;
  logic [TotalChunksW-1:0] total_q;
  logic                    bad_out_q;

  logic [PW-1:0] m;
  logic [TW-1:0] total;
  logic          is_req, bad_now, room, own_now, found, hit_now;
  logic [WW-1:0] id_t, steal_tgt, tgt_now;
  logic [MAX_WORKERS-1:0] steal_mask;

  logic [2*PW-1:0] ram_rdata, ram_wdata;
  logic [PW-1:0]   cur_front, cur_back, nxt_front, nxt_back, off;
  logic [WW+PW-1:0] prod;
  logic [XW-1:0]    idx_full;
  logic             commit_hit;

  // effective chunks per worker
  assign m     = (wc_q == WCW'(1)) ? PW'(1) : cpw_q;
  assign total = TW'(wc_q) * TW'(m);

  // ---- configuration writes (saturating) ----
  assign wc_raw  = cfg_data_i[WorkerCountW-1:0];
  assign cpw_raw = cfg_data_i[ChunksPerWorkerW-1:0];

  always_comb begin
    wc_d   = wc_q;
    cpw_d  = cpw_q;
    refill = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WORKER_COUNT: begin
          refill = 1'b1;
          if (wc_raw == '0) begin
            wc_d = WCW'(1);
          end else if (32'(wc_raw) > MAX_WORKERS) begin
            wc_d = WCW'(MAX_WORKERS);
          end else begin
            wc_d = WCW'(wc_raw);
          end
        end
        CFG_CHUNKS_PER_WORKER: begin
          refill = 1'b1;
          if (cpw_raw == '0) begin
            cpw_d = PW'(1);
          end else if (32'(cpw_raw) > MAX_CHUNKS_PER_WORKER) begin
            cpw_d = PW'(MAX_CHUNKS_PER_WORKER);
          end else begin
            cpw_d = PW'(cpw_raw);
          end
        end
        default: begin
          refill = 1'b0;
        end
      endcase
    end
  end

  // ---- request decode at accept ----
  assign id_t    = WW'(worker_id_i);
  assign is_req  = (func_e'(func_i) == FUNC_REQUEST);
  assign bad_now = is_req && (32'(worker_id_i) >= 32'(wc_q));
  assign room    = is_req && !bad_now && (32'(cnt_q) < 32'(total));
  assign own_now = room && avail_q[id_t];

  // lowest-numbered other worker in range with chunks left
  always_comb begin
    steal_tgt = '0;
    found     = 1'b0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      steal_mask[i] = avail_q[i] && (i < 32'(wc_q)) && (i != 32'(worker_id_i));
    end
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (steal_mask[i]) begin
        steal_tgt = WW'(i);
        found     = 1'b1;
      end
    end
  end

  assign hit_now = own_now || (room && found);
  assign tgt_now = own_now ? id_t : steal_tgt;

  assign sts_o.hit      = hit_now;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // ---- queue table: {front, back} per worker ----
  wsca_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WORKERS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (commit_hit),
    .waddr_i (tgt_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept && hit_now),
    .raddr_i (tgt_now),
    .rdata_o (ram_rdata)
  );

  // an entry not written since the last refill is {0, M}
  assign cur_front = vld_q[tgt_q] ? ram_rdata[2*PW-1:PW] : '0;
  assign cur_back  = vld_q[tgt_q] ? ram_rdata[PW-1:0]    : m;
  assign nxt_front = own_q ? cur_front + PW'(1) : cur_front;
  assign nxt_back  = own_q ? cur_back : cur_back - PW'(1);
  assign off       = own_q ? cur_front : nxt_back;
  assign ram_wdata = {nxt_front, nxt_back};

  assign prod       = (WW + PW)'(tgt_q) * (WW + PW)'(m);
  assign idx_full   = {1'b0, prod} + XW'(off);
  assign commit_hit = cmd_i.commit && hit_q;

  always_comb begin
    vld_d   = vld_q;
    avail_d = avail_q;
    cnt_d   = cnt_q;
    if (refill || (cmd_i.accept && func_e'(func_i) == FUNC_RESTART)) begin
      vld_d   = '0;
      avail_d = '1;
      cnt_d   = '0;
    end else if (commit_hit) begin
      vld_d[tgt_q]   = 1'b1;
      avail_d[tgt_q] = (nxt_front < nxt_back);
      cnt_d          = cnt_q + CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q        <= WCW'(1);
      cpw_q       <= PW'(1);
      vld_q       <= '0;
      avail_q     <= '1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wc_q        <= wc_d;
      cpw_q       <= cpw_d;
      vld_q       <= vld_d;
      avail_q     <= avail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hit_q <= hit_now;
      own_q <= own_now;
      bad_q <= bad_now;
      tgt_q <= tgt_now;
    end
    if (cmd_i.commit) begin
      granted_q <= hit_q;
      idx_q     <= hit_q ? ChunkIndexW'(idx_full) : '0;
      total_q   <= TotalChunksW'(total);
      bad_out_q <= bad_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign chunk_index_o  = idx_q;
  assign pool_size_o    = total_q;
  assign bad_worker_o   = bad_out_q;

endmodule

@@ hdl/work_stealing_chunk_allocator.sv @@
// Work-stealing chunk allocator. A request (func 0) pops the front of the
// requester's own queue, or else steals the back chunk of the lowest-numbered
// other worker with chunks left; a restart (func 1) or any configuration write
// refills every queue at once, with no clearing pass. One result per item. A
// granted request goes through accept with steal search, queue-table read and
// read-modify-write; restart, bad id and pool-exhausted items skip the read.
// The steps are set by the queue table's registered read and its write-back.
// A new item is accepted only after the last one commits. The result sits in
// an output register; the next item is accepted while it waits, and the block
// holds off loading a new result until the waiting one is taken.
module work_stealing_chunk_allocator #(
  parameter int MAX_WORKERS           = wsca_pkg::MaxWorkers,
  parameter int MAX_CHUNKS_PER_WORKER = wsca_pkg::MaxChunksPerWorker
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wsca_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wsca_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [wsca_pkg::WorkerIdW-1:0]    worker_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              granted_o,
  output logic [wsca_pkg::ChunkIndexW-1:0]  chunk_index_o,
  output logic [wsca_pkg::TotalChunksW-1:0] pool_size_o,
  output logic                              bad_worker_o
);

  import wsca_pkg::*;

  wsca_cmd_t cmd;
  wsca_sts_t sts;

  wsca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsca_dp #(
    .MAX_WORKERS           (MAX_WORKERS),
    .MAX_CHUNKS_PER_WORKER (MAX_CHUNKS_PER_WORKER)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .worker_id_i    (worker_id_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .granted_o      (granted_o),
    .chunk_index_o  (chunk_index_o),
    .pool_size_o    (pool_size_o),
    .bad_worker_o   (bad_worker_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ hdl/wsca_checker.sv @@
`include "work_stealing_chunk_allocator_macros.svh"

module wsca_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              granted_o,
  input logic [wsca_pkg::ChunkIndexW-1:0]  chunk_index_o,
  input logic [wsca_pkg::TotalChunksW-1:0] pool_size_o,
  input logic                              bad_worker_o
);

  // stalled beat stays put
  `WSCA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(chunk_index_o) && $stable(granted_o), "stalled result beat changed")

  `WSCA_ASSERT(a_idx_zero, out_valid_o && !granted_o |-> chunk_index_o == '0, "chunk index not zero without grant")

  `WSCA_ASSERT(a_grant_bad, out_valid_o && granted_o |-> !bad_worker_o, "grant flagged as bad worker")

  `WSCA_ASSERT(a_total_nz, out_valid_o |-> pool_size_o != '0, "pool size is zero")

  // reset clears the result register by the next edge
  `WSCA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result beat during reset")

endmodule

bind work_stealing_chunk_allocator wsca_checker u_wsca_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import wsca_pkg::*;

  localparam int StallLimit = 2000;

  typedef struct packed {
    logic                    granted;
    logic [ChunkIndexW-1:0]  chunk_index;
    logic [TotalChunksW-1:0] pool_size;
    logic                    bad_worker;
  } alloc_t;

  typedef struct packed {
    func_e                func;
    logic [WorkerIdW-1:0] worker_id;
  } request_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i = CFG_WORKER_COUNT;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    func_i = FUNC_REQUEST;
  logic [WorkerIdW-1:0]    worker_id_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    granted_o;
  logic [ChunkIndexW-1:0]  chunk_index_o;
  logic [TotalChunksW-1:0] pool_size_o;
  logic                    bad_worker_o;

  // predictor state
  logic [WorkerCountW-1:0]     workers;
  logic [ChunksPerWorkerW-1:0] chunks_per;
  logic [ChunksPerWorkerW-1:0] q_head [MaxWorkers];
  logic [ChunksPerWorkerW-1:0] q_tail [MaxWorkers];
  logic [TotalChunksW-1:0]     taken;

  request_t requests_pending[$];
  alloc_t   allocations_due[$];
  int       errors = 0;
  int       issued = 0;
  int       idle_cycles = 0;
  bit       steady = 1'b0;

  work_stealing_chunk_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .worker_id_i   (worker_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .granted_o     (granted_o),
    .chunk_index_o (chunk_index_o),
    .pool_size_o   (pool_size_o),
    .bad_worker_o  (bad_worker_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int per_worker();
    return (workers == 1) ? 1 : int'(chunks_per);
  endfunction

  function automatic void refill_queues();
    for (int w = 0; w < MaxWorkers; w++) begin
      q_head[w] = '0;
      q_tail[w] = ChunksPerWorkerW'(per_worker());
    end
    taken = '0;
  endfunction

  function automatic void apply_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    int v;
    if (idx == CFG_WORKER_COUNT) begin
      v = int'(data) & 'h1f;
      if (v == 0) v = 1;
      if (v > MaxWorkers) v = MaxWorkers;
      workers = WorkerCountW'(v);
    end else begin
      v = int'(data);
      if (v == 0) v = 1;
      if (v > MaxChunksPerWorker) v = MaxChunksPerWorker;
      chunks_per = ChunksPerWorkerW'(v);
    end
    refill_queues();
  endfunction

  function automatic alloc_t predict_allocation(func_e func, logic [WorkerIdW-1:0] id);
    alloc_t r;
    int     m;
    int     total;
    int     idx;
    bit     found;
    m = per_worker();
    total = int'(workers) * m;
    r = '0;
    r.pool_size = TotalChunksW'(total);
    found = 1'b0;
    if (func == FUNC_RESTART) begin
      refill_queues();
    end else if (id >= workers) begin
      r.bad_worker = 1'b1;
    end else if (int'(taken) < total) begin
      if (q_head[id] < q_tail[id]) begin
        idx = int'(id) * m + int'(q_head[id]);
        q_head[id] = q_head[id] + 1'b1;
        found = 1'b1;
      end else begin
        // steal from the back of the lowest-numbered other worker
        for (int v = 0; v < int'(workers); v++) begin
          if (!found && v != int'(id) && q_tail[v] > q_head[v]) begin
            q_tail[v] = q_tail[v] - 1'b1;
            idx = v * m + int'(q_tail[v]);
            found = 1'b1;
          end
        end
      end
      if (found) begin
        taken = taken + 1'b1;
        r.granted = 1'b1;
        r.chunk_index = ChunkIndexW'(idx);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic queue_request(func_e f, int id);
    request_t r;
    r.func = f;
    r.worker_id = WorkerIdW'(id);
    requests_pending.push_back(r);
    issued++;
  endtask

  task automatic write_register(cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    apply_register(idx, CfgDataW'(value));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block idle: nothing queued, nothing on the input, every result back
  task automatic wait_drained();
    while (requests_pending.size() != 0 || in_valid_i || allocations_due.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // input driver; prediction happens at the accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i)
        allocations_due.push_back(predict_allocation(func_e'(func_i), worker_id_i));
      if (requests_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
        req = requests_pending.pop_front();
        in_valid_i <= 1'b1;
        func_i <= req.func;
        worker_id_i <= req.worker_id;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < 20);
      if (out_valid_o && !out_stall_i) begin
        if (allocations_due.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = allocations_due.pop_front();
          if (granted_o !== want.granted)
            report_mismatch("granted", granted_o, want.granted);
          if (chunk_index_o !== want.chunk_index)
            report_mismatch("chunk_index", chunk_index_o, want.chunk_index);
          if (pool_size_o !== want.pool_size)
            report_mismatch("pool_size", pool_size_o, want.pool_size);
          if (bad_worker_o !== want.bad_worker)
            report_mismatch("bad_worker", bad_worker_o, want.bad_worker);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int split;
    int favored;
    int roll;
    int total;
    bit biased;
    workers = 1;
    chunks_per = 1;
    refill_queues();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset config, one chunk: grant, exhaustion, bad ids, restart
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 1);
    queue_request(FUNC_REQUEST, 15);
    queue_request(FUNC_RESTART, 15);
    queue_request(FUNC_REQUEST, 0);
    wait_drained();

    // two workers of two: own pops, a steal, then pool exhausted
    write_register(CFG_WORKER_COUNT, 2);
    write_register(CFG_CHUNKS_PER_WORKER, 2);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 1);
    queue_request(FUNC_REQUEST, 1);
    queue_request(FUNC_REQUEST, 2);
    queue_request(FUNC_RESTART, 0);
    queue_request(FUNC_REQUEST, 1);
    wait_drained();

    // zero reads as one; single worker forces one chunk even at saturated size
    write_register(CFG_WORKER_COUNT, 0);
    write_register(CFG_CHUNKS_PER_WORKER, 127);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 5);
    wait_drained();

    // saturated worker count, zero chunk size
    write_register(CFG_CHUNKS_PER_WORKER, 0);
    write_register(CFG_WORKER_COUNT, 31);
    queue_request(FUNC_REQUEST, 15);
    queue_request(FUNC_REQUEST, 15);
    queue_request(FUNC_REQUEST, 0);
    queue_request(FUNC_REQUEST, 10);
    queue_request(FUNC_RESTART, 10);
    queue_request(FUNC_REQUEST, 14);
    wait_drained();

    for (int phase = 0; issued < 1050; phase++) begin
      if (phase == 2) begin
        write_register(CFG_WORKER_COUNT, 16);
        write_register(CFG_CHUNKS_PER_WORKER, 64);
      end else if ($urandom_range(0, 4) == 0) begin
        write_register(CFG_WORKER_COUNT, $urandom_range(0, 127));
        write_register(CFG_CHUNKS_PER_WORKER, $urandom_range(0, 127));
      end else begin
        write_register(CFG_CHUNKS_PER_WORKER, $urandom_range(1, 8));
        write_register(CFG_WORKER_COUNT, $urandom_range(1, 16));
      end
      total = int'(workers) * per_worker();
      n = total + $urandom_range(2, total / 2 + 4);
      if (n > 160) n = 160;
      if (n > 1050 - issued) n = 1050 - issued;
      favored = $urandom_range(0, int'(workers) - 1);
      biased = $urandom_range(0, 1);
      steady = (phase == 2);
      if (phase == 2) begin
        // hammer the last worker so its own queue runs out and it steals
        favored = 15;
        biased = 1'b1;
      end
      split = (phase % 3 == 1) ? $urandom_range(1, n - 1) : n;
      for (int k = 0; k < n; k++) begin
        if (k == split) wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < 6)
          queue_request(FUNC_RESTART, $urandom_range(0, 15));
        else if (roll < 12)
          queue_request(FUNC_REQUEST, $urandom_range(0, 15));
        else if (biased && roll < 75)
          queue_request(FUNC_REQUEST, favored);
        else
          queue_request(FUNC_REQUEST, $urandom_range(0, int'(workers) - 1));
      end
      wait_drained();
      steady = 1'b0;
    end

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
